// File: rtl/core/csm_pkg.sv
package csm_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int EA_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = EA_W + 1;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 256;
    localparam int RA_W        = $clog2(MAX_ROWS);
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 8;
    localparam int DIM_W       = 9;

    localparam logic       KIND_SET = 1'b0;
    localparam logic       KIND_GET = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic       REG_ROWS = 1'b0;
    localparam logic       REG_COLS = 1'b1;

    typedef logic [CNT_W-1:0] t_cnt;

endpackage

// File: rtl/core/csm_in_if.sv
interface csm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [csm_pkg::IDX_W-1:0]   row_index;
    logic [csm_pkg::IDX_W-1:0]   column_index;
    logic signed [csm_pkg::VAL_W-1:0] write_value;

    modport source (output valid, kind, row_index, column_index, write_value, input ready);
    modport sink   (input valid, kind, row_index, column_index, write_value, output ready);
endinterface

// File: rtl/core/csm_out_if.sv
interface csm_out_if;
    logic                        valid;
    logic                        ready;
    logic signed [csm_pkg::VAL_W-1:0] read_value;
    logic [1:0]                  status;
    logic [csm_pkg::CNT_W-1:0]   stored_count;

    modport source (output valid, read_value, status, stored_count, input ready);
    modport sink   (input valid, read_value, status, stored_count, output ready);
endinterface

// File: rtl/core/csr_sparse_matrix_store.sv
// Sparse matrix store in compressed sparse row form.
// Input channel i_in carries set (kind 0) and get (kind 1) items; every
// item gives exactly one transfer on o_out: read value, status and the
// stored entry count after the item.
// Rows and columns in use are set through the APB port (row count at 0,
// column count at 4); write them only while the block is idle.
// One item is handled at a time by a small sequencer driving one read
// port per store; i_in.ready is low from acceptance until the result
// has been taken. An out-of-range item is answered without a lookup; a
// lookup reads the row bounds and scans the row's entries; an insert
// then shifts the later entries up by one and increments the row
// pointers of all following rows. After reset the row pointer store is
// cleared, one row a cycle, for all 256 rows; i_in.ready stays low
// during that pass.
// When o_out is stalled the result holds in the output register and no
// new item is taken until it has been transferred.
module csr_sparse_matrix_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csm_in_if.sink      i_in,
    csm_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int EA_W  = csm_pkg::EA_W;
    localparam int CNT_W = csm_pkg::CNT_W;
    localparam int RA_W  = csm_pkg::RA_W;
    localparam int VAL_W = csm_pkg::VAL_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RLO  = 4'd2;
    localparam logic [3:0] S_GLO  = 4'd3;
    localparam logic [3:0] S_RHI  = 4'd4;
    localparam logic [3:0] S_GHI  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_VAL  = 4'd8;
    localparam logic [3:0] S_DEC  = 4'd9;
    localparam logic [3:0] S_SHR  = 4'd10;
    localparam logic [3:0] S_SHW  = 4'd11;
    localparam logic [3:0] S_INS  = 4'd12;
    localparam logic [3:0] S_RIR  = 4'd13;
    localparam logic [3:0] S_RIW  = 4'd14;

    logic [csm_pkg::DIM_W-1:0] row_count, col_count;

    csm_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_row_count(row_count), .o_col_count(col_count)
    );

    logic [3:0]             r_state;
    logic                   r_kind;
    logic [RA_W-1:0]        r_row;
    logic [7:0]             r_col;
    logic [VAL_W-1:0]       r_val;
    csm_pkg::t_cnt          r_lo, r_hi, r_k, r_pos, r_count;
    logic                   r_pos_set;
    logic                   r_ov;
    logic [VAL_W-1:0]       r_rv;
    logic [1:0]             r_st;

    // store ports
    logic                   ent_we;
    logic [EA_W-1:0]        ent_waddr, ent_raddr;
    logic [VAL_W-1:0]       val_wdata, val_rdata;
    logic [7:0]             col_wdata, col_rdata;
    logic                   rs_we;
    logic [RA_W-1:0]        rs_waddr, rs_raddr;
    csm_pkg::t_cnt          rs_wdata, rs_rdata, rs_clamped, k_dec;
    logic                   val_we;

    // row_starts[j] for j >= 1 sits at address j-1; row_starts[0] is always zero
    csm_ram #(.W(VAL_W), .D(csm_pkg::MAX_ENTRIES)) u_val (
        .i_clk, .i_we(val_we), .i_waddr(ent_waddr), .i_wdata(val_wdata),
        .i_raddr(ent_raddr), .o_rdata(val_rdata)
    );
    csm_ram #(.W(8), .D(csm_pkg::MAX_ENTRIES)) u_col (
        .i_clk, .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(col_wdata),
        .i_raddr(ent_raddr), .o_rdata(col_rdata)
    );
    csm_ram #(.W(CNT_W), .D(csm_pkg::MAX_ROWS)) u_rs (
        .i_clk, .i_we(rs_we), .i_waddr(rs_waddr), .i_wdata(rs_wdata),
        .i_raddr(rs_raddr), .o_rdata(rs_rdata)
    );

    assign rs_clamped = (rs_rdata > r_count) ? r_count : rs_rdata;
    assign k_dec      = r_k - CNT_W'(1);

    always_comb begin
        ent_we    = 1'b0;
        val_we    = 1'b0;
        ent_waddr = r_k[EA_W-1:0];
        ent_raddr = r_k[EA_W-1:0];
        val_wdata = val_rdata;
        col_wdata = col_rdata;
        rs_we     = 1'b0;
        rs_waddr  = k_dec[RA_W-1:0];
        rs_raddr  = k_dec[RA_W-1:0];
        rs_wdata  = rs_rdata + CNT_W'(1);
        case (r_state)
            S_CLR: begin
                rs_we    = 1'b1;
                rs_waddr = r_k[RA_W-1:0];
                rs_wdata = '0;
            end
            S_RLO:  rs_raddr = r_row - RA_W'(1);
            S_RHI:  rs_raddr = r_row;
            S_CHK: begin
                if (col_rdata == r_col && r_kind == csm_pkg::KIND_SET) begin
                    val_we    = 1'b1;
                    val_wdata = r_val;
                end
            end
            S_SHR:  ent_raddr = k_dec[EA_W-1:0];
            S_SHW: begin
                ent_we = 1'b1;
                val_we = 1'b1;
            end
            S_INS: begin
                ent_we    = 1'b1;
                val_we    = 1'b1;
                ent_waddr = r_pos[EA_W-1:0];
                val_wdata = r_val;
                col_wdata = r_col;
            end
            S_RIW:  rs_we = 1'b1;
            default: ;
        endcase
    end

    assign i_in.ready         = (r_state == S_IDLE) && !r_ov;
    assign o_out.valid        = r_ov;
    assign o_out.read_value   = r_rv;
    assign o_out.status       = r_st;
    assign o_out.stored_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_k       <= '0;
            r_count   <= '0;
            r_ov      <= 1'b0;
            r_pos_set <= 1'b0;
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_k <= r_k + CNT_W'(1);
                    if (r_k == CNT_W'(csm_pkg::MAX_ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_kind <= i_in.kind;
                        r_row  <= i_in.row_index;
                        r_col  <= i_in.column_index;
                        r_val  <= i_in.write_value;
                        if ({1'b0, i_in.row_index} >= row_count ||
                            {1'b0, i_in.column_index} >= col_count) begin
                            r_ov <= 1'b1;
                            r_rv <= '0;
                            r_st <= csm_pkg::ST_RANGE;
                        end else if (i_in.row_index == '0) begin
                            r_lo    <= '0;
                            r_state <= S_RHI;
                        end else begin
                            r_state <= S_RLO;
                        end
                    end
                end
                S_RLO:  r_state <= S_GLO;
                S_GLO: begin
                    r_lo    <= rs_clamped;
                    r_state <= S_RHI;
                end
                S_RHI:  r_state <= S_GHI;
                S_GHI: begin
                    r_hi      <= rs_clamped;
                    r_k       <= r_lo;
                    r_pos_set <= 1'b0;
                    r_state   <= S_SCAN;
                end
                S_SCAN: r_state <= (r_k < r_hi) ? S_CHK : S_DEC;
                S_CHK: begin
                    if (col_rdata == r_col) begin
                        if (r_kind == csm_pkg::KIND_GET) begin
                            r_state <= S_VAL;
                        end else begin
                            r_ov    <= 1'b1;
                            r_rv    <= '0;
                            r_st    <= csm_pkg::ST_OK;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (col_rdata > r_col && !r_pos_set) begin
                            r_pos     <= r_k;
                            r_pos_set <= 1'b1;
                        end
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_VAL: begin
                    r_ov    <= 1'b1;
                    r_rv    <= val_rdata;
                    r_st    <= csm_pkg::ST_OK;
                    r_state <= S_IDLE;
                end
                S_DEC: begin
                    r_rv <= '0;
                    if (r_kind == csm_pkg::KIND_GET) begin
                        r_ov    <= 1'b1;
                        r_st    <= csm_pkg::ST_OK;
                        r_state <= S_IDLE;
                    end else if (r_val == '0) begin
                        r_ov    <= 1'b1;
                        r_st    <= csm_pkg::ST_ZERO;
                        r_state <= S_IDLE;
                    end else if (r_count == CNT_W'(csm_pkg::MAX_ENTRIES)) begin
                        r_ov    <= 1'b1;
                        r_st    <= csm_pkg::ST_FULL;
                        r_state <= S_IDLE;
                    end else begin
                        if (!r_pos_set) begin
                            r_pos <= r_hi;
                        end
                        r_k     <= r_count;
                        r_state <= S_SHR;
                    end
                end
                S_SHR:  r_state <= (r_k > r_pos) ? S_SHW : S_INS;
                S_SHW: begin
                    r_k     <= k_dec;
                    r_state <= S_SHR;
                end
                S_INS: begin
                    r_count <= r_count + CNT_W'(1);
                    r_k     <= CNT_W'(r_row) + CNT_W'(1);
                    r_state <= S_RIR;
                end
                S_RIR: begin
                    if (r_k <= CNT_W'(csm_pkg::MAX_ROWS)) begin
                        r_state <= S_RIW;
                    end else begin
                        r_ov    <= 1'b1;
                        r_rv    <= '0;
                        r_st    <= csm_pkg::ST_OK;
                        r_state <= S_IDLE;
                    end
                end
                S_RIW: begin
                    r_k     <= r_k + CNT_W'(1);
                    r_state <= S_RIR;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/csm_ram.sv
module csm_ram #(
    parameter int W = 32,
    parameter int D = 1024,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/csm_cfg.sv
module csm_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [csm_pkg::DIM_W-1:0] o_row_count,
    output logic [csm_pkg::DIM_W-1:0] o_col_count
);
    logic [csm_pkg::DIM_W-1:0] r_rows;
    logic [csm_pkg::DIM_W-1:0] r_cols;
    logic                      wr;

    assign wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= csm_pkg::DIM_W'(csm_pkg::MAX_ROWS);
            r_cols <= csm_pkg::DIM_W'(csm_pkg::MAX_COLUMNS);
        end else if (wr) begin
            if (paddr[2] == csm_pkg::REG_ROWS) begin
                r_rows <= pwdata[csm_pkg::DIM_W-1:0];
            end else begin
                r_cols <= pwdata[csm_pkg::DIM_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == csm_pkg::REG_ROWS) begin
            prdata[csm_pkg::DIM_W-1:0] = r_rows;
        end else begin
            prdata[csm_pkg::DIM_W-1:0] = r_cols;
        end
    end

    assign pready      = 1'b1;
    assign o_row_count = r_rows;
    assign o_col_count = r_cols;
endmodule
